// ===== rtl/psca_pkg.sv =====
// Shared constants, types and helper functions of the size-class page allocator.
`timescale 1ns / 1ps

package psca_pkg;

  // Heap geometry.
  localparam int PAGE_COUNT    = 16;
  localparam int PAGE_BYTES    = 4096;
  localparam int HEADER_BYTES  = 8;
  localparam int MIN_CLASS_LOG = 3;

  localparam int ADDR_W    = 16;
  localparam int SIZE_W    = 16;
  localparam int COPY_W    = 12;
  localparam int PG_W      = $clog2(PAGE_COUNT);
  localparam int OFS_W     = $clog2(PAGE_BYTES);
  localparam int LG_W      = 4;
  localparam int RUN_W     = $clog2(PAGE_COUNT + 2);
  localparam int SLOTS_MAX = PAGE_BYTES / (HEADER_BYTES + (1 << MIN_CLASS_LOG));
  localparam int SLOT_W    = $clog2(SLOTS_MAX);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int STRIDE_W  = OFS_W + 1;
  localparam int WORD_BITS = 16;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WPP_W     = SLOT_W - BIT_W;
  localparam int MEM_AW    = PG_W + WPP_W;
  localparam int DIV_STEPS = OFS_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // Raw slot counts per class log, before clamping to the slot array size.
  localparam int SLOTS_RAW [16] = '{
    PAGE_BYTES / (HEADER_BYTES + (1 << 0)),  PAGE_BYTES / (HEADER_BYTES + (1 << 1)),
    PAGE_BYTES / (HEADER_BYTES + (1 << 2)),  PAGE_BYTES / (HEADER_BYTES + (1 << 3)),
    PAGE_BYTES / (HEADER_BYTES + (1 << 4)),  PAGE_BYTES / (HEADER_BYTES + (1 << 5)),
    PAGE_BYTES / (HEADER_BYTES + (1 << 6)),  PAGE_BYTES / (HEADER_BYTES + (1 << 7)),
    PAGE_BYTES / (HEADER_BYTES + (1 << 8)),  PAGE_BYTES / (HEADER_BYTES + (1 << 9)),
    PAGE_BYTES / (HEADER_BYTES + (1 << 10)), PAGE_BYTES / (HEADER_BYTES + (1 << 11)),
    PAGE_BYTES / (HEADER_BYTES + (1 << 12)), PAGE_BYTES / (HEADER_BYTES + (1 << 13)),
    PAGE_BYTES / (HEADER_BYTES + (1 << 14)), PAGE_BYTES / (HEADER_BYTES + (1 << 15))
  };

  // Command codes.
  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OOM      = 3'd1,
    ST_BAD_PAGE = 3'd2,
    ST_NOT_BUSY = 3'd3,
    ST_UNSUP    = 3'd4
  } status_t;

  // Page kinds kept in the page table.
  typedef enum logic [1:0] {
    K_FREE  = 2'd0,
    K_SMALL = 2'd1,
    K_HEAD  = 2'd2,
    K_BODY  = 2'd3
  } kind_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_LOCATE,
    OP_DIV_INIT,
    OP_DIV,
    OP_LRD,
    OP_LCHK,
    OP_FREE_RUN,
    OP_ALLOC,
    OP_SRD,
    OP_SCHK,
    OP_REL_PREP,
    OP_RELEASE,
    OP_RESP
  } op_t;

  typedef struct packed {
    op_t     op;
    logic    st_we;
    status_t st_val;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic page_oob;
    logic kind_bad;
    logic kind_head;
    logic div_last;
    logic k_oob;
    logic busy;
    logic fits;
    logic is_small;
    logic small_hit;
    logic free_hit;
    logic large_hit;
    logic scan_hit;
    logic scan_last;
    logic clr_last;
    logic out_full;
  } flags_t;

  // Slots in a small page of the given class.
  function automatic logic [CNT_W-1:0] slots_of(input logic [LG_W-1:0] lg);
    if (SLOTS_RAW[lg] > SLOTS_MAX) begin
      return CNT_W'(SLOTS_MAX);
    end
    return CNT_W'(SLOTS_RAW[lg]);
  endfunction

  // Header plus class bytes of one slot.
  function automatic logic [STRIDE_W-1:0] stride_of(input logic [LG_W-1:0] lg);
    return STRIDE_W'(HEADER_BYTES) + (STRIDE_W'(1) << lg);
  endfunction

endpackage

// ===== rtl/page_size_class_allocator.sv =====
// Top level of the size-class page allocator.
`timescale 1ns / 1ps

//  Channel    Dir  Beat contents (low bit first)
//  s_axis_*   in   tdata: cmd[1:0], req_size[17:2], addr[33:18]
//  m_axis_*   out  tdata: status[2:0], block_addr[18:3], copy_bytes[30:19]
//
//  After reset the slot busy memory is swept, one word per cycle, through all 256 words
//  before the first beat is taken. A request runs to its end before the next beat is
//  accepted: the address lookup runs a 12-step divider, and a small allocation reads
//  the page's busy words, 16 slots each, in turn through the memory's single read port.
//  A finished result waits in the output register while the next beat is accepted.

module page_size_class_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // cmd, req_size, addr
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // status, block_addr, copy_bytes
);

  psca_pkg::ctrl_t  ctrl;
  psca_pkg::flags_t flags;

  // Sequencer.
  psca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .flags     (flags),
    .ctrl      (ctrl)
  );

  // Page table, busy memory and result register.
  psca_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .flags     (flags),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ===== rtl/psca_dp.sv =====
// Datapath of the allocator: page table, slot busy memory, divider and result register.
`timescale 1ns / 1ps

module psca_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  psca_pkg::ctrl_t       ctrl,
  output psca_pkg::flags_t      flags,
  input  logic [39:0]           in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_data
);

  localparam int PC    = psca_pkg::PAGE_COUNT;
  localparam int PG_W  = psca_pkg::PG_W;
  localparam int OFS_W = psca_pkg::OFS_W;
  localparam int LG_W  = psca_pkg::LG_W;
  localparam int RUN_W = psca_pkg::RUN_W;
  localparam int SW    = psca_pkg::SLOT_W;
  localparam int CW    = psca_pkg::CNT_W;
  localparam int BW    = psca_pkg::BIT_W;
  localparam int WB    = psca_pkg::WORD_BITS;
  localparam int WPW   = psca_pkg::WPP_W;
  localparam int AW    = psca_pkg::ADDR_W;
  localparam int ZW    = psca_pkg::SIZE_W;
  localparam int MAW   = psca_pkg::MEM_AW;
  localparam int STW   = psca_pkg::STRIDE_W;
  localparam int SMW   = OFS_W - 1;

  // Page table.
  psca_pkg::kind_t        page_kind       [PC];
  logic [LG_W-1:0]        page_class_log  [PC];
  logic [CW-1:0]          page_free_slots [PC];
  logic [RUN_W-1:0]       page_run_length [PC];

  // Slot busy marks, one word per group of slots of a page.
  logic [WB-1:0]          slot_mem [2**MAW];
  logic [WB-1:0]          rd_data;
  logic                   mem_we;
  logic [MAW-1:0]         mem_wa;
  logic [WB-1:0]          mem_wd;
  logic                   mem_re;
  logic [MAW-1:0]         mem_ra;

  // Request and working registers.
  psca_pkg::cmd_t         cmd_r;
  logic [ZW-1:0]          size_r;
  logic [AW-1:0]          addr_r;
  logic [PG_W-1:0]        pg;
  logic [SW-1:0]          k;
  logic [LG_W-1:0]        lg;
  logic [WPW-1:0]         w;
  logic [PG_W-1:0]        opg;
  logic [SW-1:0]          ok_slot;
  logic [LG_W-1:0]        olg;
  logic [WB-1:0]          owd;
  logic [OFS_W:0]         rem;
  logic [OFS_W-1:0]       quo;
  logic [psca_pkg::DIV_CW-1:0] div_cnt;
  logic [MAW-1:0]         clr_cnt;
  psca_pkg::status_t      st;
  logic [AW-1:0]          baddr;
  logic [psca_pkg::COPY_W-1:0] copy;

  // Block data address from page, slot and class.
  function automatic logic [AW-1:0] blk_addr(input logic [PG_W-1:0] p,
                                             input logic [SW-1:0] s,
                                             input logic [LG_W-1:0] l);
    logic [SW+STW-1:0] prod;
    prod = SW'(s) * psca_pkg::stride_of(l);
    return (AW'(p) << OFS_W) + AW'(prod[OFS_W-1:0]) + AW'(psca_pkg::HEADER_BYTES);
  endfunction

  // Current page fields.
  psca_pkg::kind_t cur_kind;
  logic [LG_W-1:0] cur_lg;
  logic [STW-1:0]  cur_stride;
  assign cur_kind   = page_kind[pg];
  assign cur_lg     = page_class_log[pg];
  assign cur_stride = psca_pkg::stride_of(cur_lg);

  // Divider step: offset into page divided by the slot stride.
  logic [OFS_W:0] rem_sh;
  logic           div_ge;
  assign rem_sh = {rem[OFS_W-1:0], quo[OFS_W-1]};
  assign div_ge = rem_sh >= (OFS_W+1)'(cur_stride);

  // Size class of a small request.
  logic [SMW-1:0]  sm1;
  logic [LG_W-1:0] req_lg;
  always_comb begin
    sm1 = size_r[SMW-1:0] - SMW'(1);
    req_lg = LG_W'(psca_pkg::MIN_CLASS_LOG);
    if (size_r > ZW'(1 << psca_pkg::MIN_CLASS_LOG)) begin
      for (int i = 0; i < SMW; i++) begin
        if (sm1[i]) begin
          req_lg = LG_W'(i + 1);
        end
      end
    end
  end

  // Page searches over the page table.
  logic            small_hit, free_hit, large_hit, is_small;
  logic [PG_W-1:0] small_pg, free_pg, large_pg;
  logic [ZW:0]     big_sum;
  logic [RUN_W-1:0] need;
  logic [PC:0]     free_vec, need_mask;
  always_comb begin
    is_small  = size_r < ZW'(psca_pkg::PAGE_BYTES / 2);
    small_hit = 1'b0;
    free_hit  = 1'b0;
    large_hit = 1'b0;
    small_pg  = '0;
    free_pg   = '0;
    large_pg  = '0;
    big_sum   = (ZW+1)'(size_r) + (ZW+1)'(psca_pkg::HEADER_BYTES + psca_pkg::PAGE_BYTES - 1);
    need      = RUN_W'(big_sum >> OFS_W);
    need_mask = ((PC+1)'(1) << need) - (PC+1)'(1);
    free_vec  = '0;
    for (int i = 0; i < PC; i++) begin
      free_vec[i] = page_kind[i] == psca_pkg::K_FREE;
    end
    for (int i = PC - 1; i >= 0; i--) begin
      if (page_kind[i] == psca_pkg::K_SMALL && page_class_log[i] == req_lg &&
          page_free_slots[i] != '0) begin
        small_hit = 1'b1;
        small_pg  = PG_W'(i);
      end
      if (page_kind[i] == psca_pkg::K_FREE) begin
        free_hit = 1'b1;
        free_pg  = PG_W'(i);
      end
      if (((free_vec >> i) & need_mask) == need_mask &&
          (32'(i) + 32'(need)) <= 32'(PC)) begin
        large_hit = 1'b1;
        large_pg  = PG_W'(i);
      end
    end
  end

  // Scan of one busy word for the first free slot.
  logic [CW-1:0]  scan_n;
  logic           scan_hit, scan_last;
  logic [BW-1:0]  scan_b;
  always_comb begin
    scan_n   = psca_pkg::slots_of(lg);
    scan_hit = 1'b0;
    scan_b   = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if ({1'b0, w, BW'(b)} < scan_n && !rd_data[b]) begin
        scan_hit = 1'b1;
        scan_b   = BW'(b);
      end
    end
    scan_last = w == WPW'((scan_n - CW'(1)) >> BW);
  end

  // Status toward the controller.
  always_comb begin
    flags.cmd       = cmd_r;
    flags.page_oob  = 32'(addr_r >> OFS_W) >= 32'(PC);
    flags.kind_bad  = cur_kind == psca_pkg::K_FREE || cur_kind == psca_pkg::K_BODY;
    flags.kind_head = cur_kind == psca_pkg::K_HEAD;
    flags.div_last  = div_cnt == psca_pkg::DIV_CW'(psca_pkg::DIV_STEPS - 1);
    flags.k_oob     = (OFS_W+1)'(quo) >= (OFS_W+1)'(psca_pkg::slots_of(cur_lg));
    flags.busy      = rd_data[k[BW-1:0]];
    flags.fits      = (ZW+1)'(1 << cur_lg) >= (ZW+1)'(size_r);
    flags.is_small  = is_small;
    flags.small_hit = small_hit;
    flags.free_hit  = free_hit;
    flags.large_hit = large_hit && need <= RUN_W'(PC);
    flags.scan_hit  = scan_hit;
    flags.scan_last = scan_last;
    flags.clr_last  = clr_cnt == {MAW{1'b1}};
    flags.out_full  = out_valid;
  end

  // Memory port control.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = {pg, k[SW-1:BW]};
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = {pg, quo[SW-1:BW]};
    case (ctrl.op)
      psca_pkg::OP_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
      end
      psca_pkg::OP_LRD: begin
        mem_re = 1'b1;
      end
      psca_pkg::OP_SRD: begin
        mem_re = 1'b1;
        mem_ra = {pg, w};
      end
      psca_pkg::OP_SCHK: begin
        mem_we = scan_hit;
        mem_wa = {pg, w};
        mem_wd = rd_data | (WB'(1) << scan_b);
      end
      psca_pkg::OP_RELEASE: begin
        mem_we = 1'b1;
        mem_wd = owd & ~(WB'(1) << k[BW-1:0]);
      end
      default: begin
      end
    endcase
  end

  // Busy memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= slot_mem[mem_ra];
    end
  end

  // Page table updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PC; i++) begin
        page_kind[i]       <= psca_pkg::K_FREE;
        page_class_log[i]  <= '0;
        page_free_slots[i] <= '0;
        page_run_length[i] <= '0;
      end
    end else begin
      case (ctrl.op)
        psca_pkg::OP_FREE_RUN: begin
          for (int i = 0; i < PC; i++) begin
            if (PG_W'(i) >= pg && (32'(i) < 32'(pg) + 32'(page_run_length[pg]))) begin
              page_kind[i] <= psca_pkg::K_FREE;
            end
          end
          page_run_length[pg] <= '0;
        end
        psca_pkg::OP_ALLOC: begin
          if (is_small) begin
            if (!small_hit && free_hit) begin
              page_kind[free_pg]       <= psca_pkg::K_SMALL;
              page_class_log[free_pg]  <= req_lg;
              page_free_slots[free_pg] <= psca_pkg::slots_of(req_lg);
            end
          end else if (flags.large_hit) begin
            for (int i = 0; i < PC; i++) begin
              if (PG_W'(i) > large_pg && (32'(i) < 32'(large_pg) + 32'(need))) begin
                page_kind[i] <= psca_pkg::K_BODY;
              end
            end
            page_kind[large_pg]       <= psca_pkg::K_HEAD;
            page_run_length[large_pg] <= need;
          end
        end
        psca_pkg::OP_SCHK: begin
          if (scan_hit) begin
            page_free_slots[pg] <= page_free_slots[pg] - CW'(1);
          end
        end
        psca_pkg::OP_RELEASE: begin
          page_free_slots[pg] <= page_free_slots[pg] + CW'(1);
          if (page_free_slots[pg] + CW'(1) >= psca_pkg::slots_of(cur_lg)) begin
            page_kind[pg] <= psca_pkg::K_FREE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      st        <= psca_pkg::ST_OK;
    end else begin
      if (ctrl.st_we) begin
        st <= ctrl.st_val;
      end
      if (ctrl.op == psca_pkg::OP_RESP) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (ctrl.op)
        psca_pkg::OP_CLEAR: begin
          clr_cnt <= clr_cnt + MAW'(1);
        end
        psca_pkg::OP_LOAD: begin
          cmd_r  <= psca_pkg::cmd_t'(in_data[1:0]);
          size_r <= in_data[2 +: ZW];
          addr_r <= in_data[2 + ZW +: AW];
          st     <= psca_pkg::ST_OK;
          baddr  <= '0;
          copy   <= '0;
        end
        psca_pkg::OP_LOCATE: begin
          pg <= addr_r[OFS_W +: PG_W];
        end
        psca_pkg::OP_DIV_INIT: begin
          rem     <= '0;
          quo     <= addr_r[OFS_W-1:0];
          div_cnt <= '0;
        end
        psca_pkg::OP_DIV: begin
          rem     <= div_ge ? rem_sh - (OFS_W+1)'(cur_stride) : rem_sh;
          quo     <= {quo[OFS_W-2:0], div_ge};
          div_cnt <= div_cnt + psca_pkg::DIV_CW'(1);
        end
        psca_pkg::OP_LRD: begin
          k <= quo[SW-1:0];
        end
        psca_pkg::OP_LCHK: begin
          opg     <= pg;
          ok_slot <= k;
          olg     <= cur_lg;
          owd     <= rd_data;
          baddr   <= blk_addr(pg, k, cur_lg);
        end
        psca_pkg::OP_ALLOC: begin
          w <= '0;
          if (is_small) begin
            lg <= req_lg;
            pg <= small_hit ? small_pg : free_pg;
          end else begin
            baddr <= (AW'(large_pg) << OFS_W) + AW'(psca_pkg::HEADER_BYTES);
          end
        end
        psca_pkg::OP_SCHK: begin
          if (scan_hit) begin
            baddr <= blk_addr(pg, {w, scan_b}, lg);
          end else begin
            w <= w + WPW'(1);
          end
        end
        psca_pkg::OP_REL_PREP: begin
          pg <= opg;
          k  <= ok_slot;
        end
        psca_pkg::OP_RELEASE: begin
          if (cmd_r == psca_pkg::CMD_REALLOC) begin
            copy <= psca_pkg::COPY_W'(1) << olg;
          end else begin
            baddr <= '0;
          end
        end
        psca_pkg::OP_RESP: begin
          out_data  <= {1'b0,
                        (st == psca_pkg::ST_OK) ? copy : psca_pkg::COPY_W'(0),
                        (st == psca_pkg::ST_OK) ? baddr : AW'(0),
                        st};
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/psca_ctrl.sv =====
// Controller state machine that sequences each allocator request.
`timescale 1ns / 1ps

module psca_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  psca_pkg::flags_t  flags,
  output psca_pkg::ctrl_t   ctrl
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_LOCATE,
    S_CLASSIFY,
    S_DIV,
    S_LRD,
    S_LCHK,
    S_ALLOC,
    S_SRD,
    S_SCHK,
    S_REL_PREP,
    S_RELEASE,
    S_RESP
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  // Next state and datapath operation.
  always_comb begin
    state_next  = state;
    ctrl.op     = psca_pkg::OP_NONE;
    ctrl.st_we  = 1'b0;
    ctrl.st_val = psca_pkg::ST_OK;
    case (state)
      S_CLEAR: begin
        ctrl.op = psca_pkg::OP_CLEAR;
        if (flags.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctrl.op    = psca_pkg::OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (flags.cmd)
          psca_pkg::CMD_ALLOC: state_next = S_ALLOC;
          psca_pkg::CMD_FREE, psca_pkg::CMD_REALLOC: state_next = S_LOCATE;
          default: begin
            ctrl.st_we  = 1'b1;
            ctrl.st_val = psca_pkg::ST_UNSUP;
            state_next  = S_RESP;
          end
        endcase
      end
      S_LOCATE: begin
        ctrl.op = psca_pkg::OP_LOCATE;
        if (flags.page_oob) begin
          ctrl.st_we  = 1'b1;
          ctrl.st_val = psca_pkg::ST_BAD_PAGE;
          state_next  = S_RESP;
        end else begin
          state_next = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        ctrl.op = psca_pkg::OP_DIV_INIT;
        if (flags.kind_bad) begin
          ctrl.st_we  = 1'b1;
          ctrl.st_val = psca_pkg::ST_BAD_PAGE;
          state_next  = S_RESP;
        end else if (flags.kind_head) begin
          if (flags.cmd == psca_pkg::CMD_FREE) begin
            ctrl.op = psca_pkg::OP_FREE_RUN;
          end else begin
            ctrl.st_we  = 1'b1;
            ctrl.st_val = psca_pkg::ST_UNSUP;
          end
          state_next = S_RESP;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        ctrl.op = psca_pkg::OP_DIV;
        if (flags.div_last) begin
          state_next = S_LRD;
        end
      end
      S_LRD: begin
        ctrl.op = psca_pkg::OP_LRD;
        if (flags.k_oob) begin
          ctrl.st_we  = 1'b1;
          ctrl.st_val = psca_pkg::ST_BAD_PAGE;
          state_next  = S_RESP;
        end else begin
          state_next = S_LCHK;
        end
      end
      S_LCHK: begin
        ctrl.op = psca_pkg::OP_LCHK;
        if (!flags.busy) begin
          ctrl.st_we  = 1'b1;
          ctrl.st_val = psca_pkg::ST_NOT_BUSY;
          state_next  = S_RESP;
        end else if (flags.cmd == psca_pkg::CMD_FREE) begin
          state_next = S_REL_PREP;
        end else if (flags.fits) begin
          state_next = S_RESP;
        end else begin
          state_next = S_ALLOC;
        end
      end
      S_ALLOC: begin
        ctrl.op = psca_pkg::OP_ALLOC;
        if (flags.is_small) begin
          if (flags.small_hit || flags.free_hit) begin
            state_next = S_SRD;
          end else begin
            ctrl.st_we  = 1'b1;
            ctrl.st_val = psca_pkg::ST_OOM;
            state_next  = S_RESP;
          end
        end else if (flags.large_hit) begin
          state_next = (flags.cmd == psca_pkg::CMD_REALLOC) ? S_REL_PREP : S_RESP;
        end else begin
          ctrl.st_we  = 1'b1;
          ctrl.st_val = psca_pkg::ST_OOM;
          state_next  = S_RESP;
        end
      end
      S_SRD: begin
        ctrl.op    = psca_pkg::OP_SRD;
        state_next = S_SCHK;
      end
      S_SCHK: begin
        ctrl.op = psca_pkg::OP_SCHK;
        if (flags.scan_hit) begin
          state_next = (flags.cmd == psca_pkg::CMD_REALLOC) ? S_REL_PREP : S_RESP;
        end else if (flags.scan_last) begin
          ctrl.st_we  = 1'b1;
          ctrl.st_val = psca_pkg::ST_OOM;
          state_next  = S_RESP;
        end else begin
          state_next = S_SRD;
        end
      end
      S_REL_PREP: begin
        ctrl.op    = psca_pkg::OP_REL_PREP;
        state_next = S_RELEASE;
      end
      S_RELEASE: begin
        ctrl.op    = psca_pkg::OP_RELEASE;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!flags.out_full || out_ready) begin
          ctrl.op    = psca_pkg::OP_RESP;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
